@@ hdl/curb_following_offset_controller_assert.svh @@
// Assertion macros shared by the controller modules.
`ifndef CURB_FOLLOWING_OFFSET_CONTROLLER_ASSERT_SVH
`define CURB_FOLLOWING_OFFSET_CONTROLLER_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define CFOC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: assertion failed");

// Checked on every rising edge, reset included.
`define CFOC_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("%m: assertion failed");

`endif

@@ hdl/cfoc_pkg.sv @@
package cfoc_pkg;

    localparam int FIT_W      = 9;
    localparam int SP_W       = 15;
    localparam int STEP_W     = 15;
    localparam int HOLD_W     = 8;
    localparam int DELTA_W    = 16;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Request kinds as they arrive in the mode field.
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NUDGE_UP = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NUDGE_DN = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TOGGLE   = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OSTEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PSTEP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF  = 3'd6;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;
    localparam int RSP_RESET = 512;

    // Decoded request class, one-hot.
    localparam int OP_W = 7;
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 7'b0000001,
        OP_LEFT     = 7'b0000010,
        OP_RIGHT    = 7'b0000100,
        OP_NUDGE_UP = 7'b0001000,
        OP_NUDGE_DN = 7'b0010000,
        OP_TOGGLE   = 7'b0100000,
        OP_IDLE     = 7'b1000000
    } t_op;

    typedef struct packed {
        logic [SP_W-1:0]   left_sp;
        logic [SP_W-1:0]   deadband;
        logic [FIT_W-1:0]  fit_thr;
        logic [SP_W-1:0]   margin;
        logic [STEP_W-1:0] ostep;
        logic [STEP_W-1:0] pstep;
        logic [HOLD_W-1:0] holdoff;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        left_sp:  15'd512,
        deadband: 15'd64,
        fit_thr:  9'd128,
        margin:   15'd512,
        ostep:    15'd192,
        pstep:    15'd38,
        holdoff:  8'd2
    };

endpackage

@@ hdl/cfoc_front.sv @@
module cfoc_front import cfoc_pkg::*; (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_q_full,
    output logic              o_push,
    output t_op               o_op
);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Unused mode codes become idle requests that only report state.
    always_comb begin
        unique case (i_mode)
            MODE_TICK:     o_op = OP_TICK;
            MODE_LEFT:     o_op = OP_LEFT;
            MODE_RIGHT:    o_op = OP_RIGHT;
            MODE_NUDGE_UP: o_op = OP_NUDGE_UP;
            MODE_NUDGE_DN: o_op = OP_NUDGE_DN;
            MODE_TOGGLE:   o_op = OP_TOGGLE;
            default:       o_op = OP_IDLE;
        endcase
    end

endmodule

@@ hdl/cfoc_queue.sv @@
`include "curb_following_offset_controller_assert.svh"

module cfoc_queue import cfoc_pkg::*; #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    `CFOC_ASSERT_NORST(a_q_reset_empty, !i_rst_n |=> (r_cnt == '0))
    `CFOC_ASSERT(a_q_no_overflow, i_push |-> !o_full)
    `CFOC_ASSERT(a_q_pop_valid, i_pop |-> o_valid)
    `CFOC_ASSERT(a_q_count_up, (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CNT_W'(1)))

endmodule

@@ hdl/cfoc_back.sv @@
`include "curb_following_offset_controller_assert.svh"

module cfoc_back import cfoc_pkg::*; #(
    parameter int DIST_WIDTH = 16,
    parameter int SUM_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_q_valid,
    output logic                         o_q_pop,
    input  t_op                          i_op,
    input  logic signed [DIST_WIDTH-1:0] i_dist,
    input  logic [FIT_W-1:0]             i_fit,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DELTA_W-1:0]    o_od,
    output logic signed [DELTA_W-1:0]    o_pd,
    output logic signed [SUM_WIDTH-1:0]  o_ot,
    output logic signed [SUM_WIDTH-1:0]  o_pt,
    output logic                         o_enabled,
    output logic                         o_lrel,
    output logic                         o_rrel
);

    // The right setpoint must hold its reset value even for narrow distances.
    localparam int RSP_W = (DIST_WIDTH > 11) ? DIST_WIDTH : 11;
    localparam int CW    = ((DIST_WIDTH > SP_W) ? DIST_WIDTH : SP_W) + 3;
    localparam logic signed [CW-1:0] D_MAX = (CW'(1) <<< (DIST_WIDTH - 1)) - CW'(1);
    localparam logic signed [CW-1:0] D_MIN = -D_MAX - CW'(1);
    localparam logic signed [SUM_WIDTH-1:0] S_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] S_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    function automatic logic signed [SUM_WIDTH-1:0] f_sat(input logic signed [SUM_WIDTH:0] x);
        logic signed [SUM_WIDTH-1:0] res;
        if (x[SUM_WIDTH] != x[SUM_WIDTH-1]) begin
            res = x[SUM_WIDTH] ? S_MIN : S_MAX;
        end else begin
            res = x[SUM_WIDTH-1:0];
        end
        return res;
    endfunction

    logic signed [DIST_WIDTH-1:0] r_lofs, n_lofs, r_rofs, n_rofs;
    logic [FIT_W-1:0]             r_lfit, n_lfit, r_rfit, n_rfit;
    logic signed [RSP_W-1:0]      r_rsp, n_rsp;
    logic [HOLD_W-1:0]            r_hold, n_hold;
    logic                         r_act, n_act;
    logic signed [SUM_WIDTH-1:0]  r_osum, n_osum, r_psum, n_psum;
    logic signed [DELTA_W-1:0]    n_od, n_pd;
    logic                         r_ovalid;

    logic signed [CW-1:0] w_ld, w_rd, w_lsp, w_rsp, w_db, w_sp_raw, w_sp_sat;
    logic                 w_due, w_lrel, w_rrel, w_decide;
    logic                 w_l_below, w_l_above, w_r_below, w_r_above;
    logic                 w_move_r, w_move_l;
    logic signed [DELTA_W-1:0]   w_ostep, w_pstep;
    logic signed [SUM_WIDTH:0]   w_osum_x, w_psum_x, w_ostep_x, w_pstep_x;
    logic signed [SUM_WIDTH-1:0] w_os_up, w_os_dn, w_ps_up, w_ps_dn;

    assign o_q_pop = i_q_valid && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;

    // Band compares for both curbs run side by side; the fit test picks one.
    always_comb begin
        w_ld  = CW'(r_lofs);
        w_rd  = -CW'(r_rofs);
        w_lsp = CW'(i_cfg.left_sp);
        w_rsp = CW'(r_rsp);
        w_db  = CW'(i_cfg.deadband);

        w_l_below = w_ld < (w_lsp - w_db);
        w_l_above = w_ld > (w_lsp + w_db);
        w_r_below = w_rd < (w_rsp - w_db);
        w_r_above = w_rd > (w_rsp + w_db);

        w_due    = r_hold > i_cfg.holdoff;
        w_lrel   = r_lfit >= i_cfg.fit_thr;
        w_rrel   = r_rfit >= i_cfg.fit_thr;
        w_decide = (i_op == OP_TICK) && w_due && r_act;

        w_move_r = w_decide && (w_lrel ? w_l_below : (w_rrel && w_r_above));
        w_move_l = w_decide && (w_lrel ? w_l_above : (w_rrel && w_r_below));

        w_sp_raw = CW'(r_lofs) - CW'(r_rofs) - CW'(i_cfg.margin);
        if (w_sp_raw > D_MAX) begin
            w_sp_sat = D_MAX;
        end else if (w_sp_raw < D_MIN) begin
            w_sp_sat = D_MIN;
        end else begin
            w_sp_sat = w_sp_raw;
        end
    end

    // Both saturated totals are formed ahead of the decision and then selected.
    always_comb begin
        w_ostep   = DELTA_W'(i_cfg.ostep);
        w_pstep   = DELTA_W'(i_cfg.pstep);
        w_osum_x  = (SUM_WIDTH+1)'(r_osum);
        w_psum_x  = (SUM_WIDTH+1)'(r_psum);
        w_ostep_x = (SUM_WIDTH+1)'(i_cfg.ostep);
        w_pstep_x = (SUM_WIDTH+1)'(i_cfg.pstep);
        w_os_up   = f_sat(w_osum_x + w_ostep_x);
        w_os_dn   = f_sat(w_osum_x - w_ostep_x);
        w_ps_up   = f_sat(w_psum_x + w_pstep_x);
        w_ps_dn   = f_sat(w_psum_x - w_pstep_x);
    end

    always_comb begin
        n_lofs = r_lofs;
        n_rofs = r_rofs;
        n_lfit = r_lfit;
        n_rfit = r_rfit;
        n_rsp  = r_rsp;
        n_hold = r_hold;
        n_act  = r_act;
        n_osum = r_osum;
        n_psum = r_psum;
        n_od   = '0;
        n_pd   = '0;
        if (o_q_pop) begin
            unique case (i_op)
                OP_TICK: begin
                    if (w_decide && w_lrel && w_rrel) begin
                        n_rsp = RSP_W'(w_sp_sat);
                    end
                    if (w_move_r) begin
                        n_od   = w_ostep;
                        n_pd   = -w_pstep;
                        n_osum = w_os_up;
                        n_psum = w_ps_dn;
                        n_hold = '0;
                    end else if (w_move_l) begin
                        n_od   = -w_ostep;
                        n_pd   = w_pstep;
                        n_osum = w_os_dn;
                        n_psum = w_ps_up;
                        n_hold = '0;
                    end else if (r_hold != HOLD_MAX) begin
                        n_hold = r_hold + HOLD_W'(1);
                    end
                end
                OP_LEFT: begin
                    n_lofs = i_dist;
                    n_lfit = i_fit;
                end
                OP_RIGHT: begin
                    n_rofs = i_dist;
                    n_rfit = i_fit;
                end
                OP_NUDGE_UP: begin
                    n_od   = w_ostep;
                    n_osum = w_os_up;
                end
                OP_NUDGE_DN: begin
                    n_od   = -w_ostep;
                    n_osum = w_os_dn;
                end
                OP_TOGGLE: begin
                    n_act = !r_act;
                end
                OP_IDLE: begin
                    n_act = r_act;
                end
                default: begin
                    n_act = r_act;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lofs   <= '0;
            r_rofs   <= '0;
            r_lfit   <= '0;
            r_rfit   <= '0;
            r_rsp    <= RSP_W'(RSP_RESET);
            r_hold   <= '0;
            r_act    <= 1'b0;
            r_osum   <= '0;
            r_psum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_lofs <= n_lofs;
            r_rofs <= n_rofs;
            r_lfit <= n_lfit;
            r_rfit <= n_rfit;
            r_rsp  <= n_rsp;
            r_hold <= n_hold;
            r_act  <= n_act;
            r_osum <= n_osum;
            r_psum <= n_psum;
            if (o_q_pop) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result register; the flags report the state left by the request.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            o_od      <= n_od;
            o_pd      <= n_pd;
            o_ot      <= n_osum;
            o_pt      <= n_psum;
            o_enabled <= n_act;
            o_lrel    <= n_lfit >= i_cfg.fit_thr;
            o_rrel    <= n_rfit >= i_cfg.fit_thr;
        end
    end

    `CFOC_ASSERT(a_b_one_dir, !(w_move_r && w_move_l))
    `CFOC_ASSERT(a_b_hold_clear, (o_q_pop && (w_move_r || w_move_l)) |=> (r_hold == '0))
    `CFOC_ASSERT(a_b_sum_stable, !o_q_pop |=> ($stable(r_osum) && $stable(r_psum)))

endmodule

@@ hdl/curb_following_offset_controller.sv @@
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser: mode; tdata: distance, fit
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: deltas, totals, flags
// cfg       in         i_cfg_we (no wait)             i_cfg_idx, i_cfg_data
//
// One request is taken per cycle and one result leaves per cycle while the
// output side keeps taking them; a request passes the queue and the result
// register before its result is presented. The rate is set by the execute
// stage, which applies one request per cycle to the controller state unless
// the output stalls; a two-entry queue sits between decode and execute.
// Reset is synchronous and active low; it restores the register defaults and
// the controller state, and empties the queue and the result register.
// A stalled output fills the queue, after which s_axis_tready drops.
`include "curb_following_offset_controller_assert.svh"

module curb_following_offset_controller import cfoc_pkg::*; #(
    parameter int DIST_WIDTH = 16,
    parameter int SUM_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Request channel.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: curb_distance (DIST_WIDTH, signed), fit_quality (9), zero fill.
    input  logic [((DIST_WIDTH + FIT_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: mode (3).
    input  logic [MODE_W-1:0]     s_axis_tuser,
    // Result channel.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0: orientation_delta (16), position_delta (16),
    // orientation_total (SUM_WIDTH), position_total (SUM_WIDTH), enabled,
    // left_reliable, right_reliable, zero fill.
    output logic [((2 * DELTA_W + 2 * SUM_WIDTH + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // Register write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int OUT_W  = 2 * DELTA_W + 2 * SUM_WIDTH + 3;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int Q_W    = OP_W + DIST_WIDTH + FIT_W;

    t_cfg r_cfg;

    // Register file. Writes to an index beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEFT_SP:  r_cfg.left_sp  <= i_cfg_data;
                CFG_DEADBAND: r_cfg.deadband <= i_cfg_data;
                CFG_FIT_THR:  r_cfg.fit_thr  <= i_cfg_data[FIT_W-1:0];
                CFG_MARGIN:   r_cfg.margin   <= i_cfg_data;
                CFG_OSTEP:    r_cfg.ostep    <= i_cfg_data;
                CFG_PSTEP:    r_cfg.pstep    <= i_cfg_data;
                CFG_HOLDOFF:  r_cfg.holdoff  <= i_cfg_data[HOLD_W-1:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    // Front: decode the mode and push the request into the queue.
    logic q_full, q_push, q_valid, q_pop;
    t_op  front_op, back_op;
    logic [Q_W-1:0] q_wdata, q_rdata;
    logic signed [DIST_WIDTH-1:0] back_dist;
    logic [FIT_W-1:0] back_fit;

    cfoc_front u_front (
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_mode   (s_axis_tuser),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_op     (front_op)
    );

    assign q_wdata = {front_op, s_axis_tdata[DIST_WIDTH-1:0],
                      s_axis_tdata[DIST_WIDTH+FIT_W-1:DIST_WIDTH]};

    cfoc_queue #(.WIDTH(Q_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    assign back_op   = t_op'(q_rdata[Q_W-1:DIST_WIDTH+FIT_W]);
    assign back_dist = q_rdata[DIST_WIDTH+FIT_W-1:FIT_W];
    assign back_fit  = q_rdata[FIT_W-1:0];

    // Back: apply the request to the controller state and hold the result.
    logic signed [DELTA_W-1:0]   res_od, res_pd;
    logic signed [SUM_WIDTH-1:0] res_ot, res_pt;
    logic                        res_en, res_lrel, res_rrel;

    cfoc_back #(
        .DIST_WIDTH (DIST_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .o_q_pop   (q_pop),
        .i_op      (back_op),
        .i_dist    (back_dist),
        .i_fit     (back_fit),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_od      (res_od),
        .o_pd      (res_pd),
        .o_ot      (res_ot),
        .o_pt      (res_pt),
        .o_enabled (res_en),
        .o_lrel    (res_lrel),
        .o_rrel    (res_rrel)
    );

    assign m_axis_tdata = OUT_TW'({res_rrel, res_lrel, res_en, res_pt, res_ot, res_pd, res_od});

    // A request is only taken when the queue has room for it.
    `CFOC_ASSERT(a_top_push_room, (s_axis_tvalid && s_axis_tready) |-> !q_full)
    `CFOC_ASSERT(a_top_ready_q, s_axis_tready == !q_full)
    `CFOC_ASSERT(a_top_pop_q, q_pop |-> q_valid)

endmodule

@@ dv/curb_following_offset_checker.sv @@
module curb_following_offset_checker import cfoc_pkg::*; #(
    parameter int IN_TW  = 32,
    parameter int OUT_TW = 104
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic [IN_TW-1:0]      i_req_data,
    input  logic [MODE_W-1:0]     i_req_mode,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic [OUT_TW-1:0]     i_res_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_corrections,
    output int                    o_clamps
);

    localparam int     RES_W    = 99;
    localparam longint DIST_MAX = 32767;
    localparam longint DIST_MIN = -32768;
    localparam longint SUM_MAX  = 64'sd2147483647;
    localparam longint SUM_MIN  = -64'sd2147483648;

    // Result fields, lowest bits last.
    typedef struct packed {
        logic               right_rel;
        logic               left_rel;
        logic               enabled;
        logic signed [31:0] pos_total;
        logic signed [31:0] orient_total;
        logic signed [15:0] pos_delta;
        logic signed [15:0] orient_delta;
    } t_steer_result;

    t_cfg               cfg;
    logic signed [15:0] left_off;
    logic signed [15:0] right_off;
    logic signed [15:0] right_sp;
    logic [FIT_W-1:0]   left_fit;
    logic [FIT_W-1:0]   right_fit;
    logic [HOLD_W-1:0]  hold_cnt;
    logic               armed;
    logic signed [31:0] orient_acc;
    logic signed [31:0] pos_acc;

    t_steer_result      awaited_steer[$];
    t_steer_result      want;
    t_steer_result      got;

    // +1 when the distance sits below the band (steer right), -1 above it.
    function automatic int band_side(longint curb_dist, longint target);
        if (curb_dist < target - longint'(cfg.deadband)) return 1;
        if (curb_dist > target + longint'(cfg.deadband)) return -1;
        return 0;
    endfunction

    function automatic logic signed [31:0] sat_sum(logic signed [31:0] acc, longint step);
        longint total;
        total = longint'(acc) + step;
        if (total > SUM_MAX) total = SUM_MAX;
        if (total < SUM_MIN) total = SUM_MIN;
        return total[31:0];
    endfunction

    function automatic t_steer_result steer_for_request(logic [MODE_W-1:0] mode,
                                                        logic [IN_TW-1:0] data);
        logic signed [15:0] curb_off;
        logic [FIT_W-1:0]   fit;
        longint             od;
        longint             pd;
        longint             target;
        logic               due;
        logic               lrel;
        logic               rrel;
        int                 dir;
        t_steer_result      r;
        curb_off = data[15:0];
        fit      = data[16 +: FIT_W];
        od       = 0;
        pd       = 0;
        dir      = 0;
        case (mode)
            MODE_LEFT: begin
                left_off = curb_off;
                left_fit = fit;
            end
            MODE_RIGHT: begin
                right_off = curb_off;
                right_fit = fit;
            end
            MODE_NUDGE_UP: od = longint'(cfg.ostep);
            MODE_NUDGE_DN: od = -longint'(cfg.ostep);
            MODE_TOGGLE:   armed = !armed;
            MODE_TICK: begin
                due  = hold_cnt > cfg.holdoff;
                lrel = left_fit >= cfg.fit_thr;
                rrel = right_fit >= cfg.fit_thr;
                if (hold_cnt != HOLD_MAX) hold_cnt = hold_cnt + 1'b1;
                if (due && armed) begin
                    if (lrel && rrel) begin
                        target = longint'(left_off) - longint'(right_off)
                                 - longint'(cfg.margin);
                        if (target > DIST_MAX || target < DIST_MIN) o_clamps++;
                        if (target > DIST_MAX) target = DIST_MAX;
                        if (target < DIST_MIN) target = DIST_MIN;
                        right_sp = target[15:0];
                        dir = band_side(left_off, cfg.left_sp);
                    end else if (lrel) begin
                        dir = band_side(left_off, cfg.left_sp);
                    end else if (rrel) begin
                        dir = -band_side(-longint'(right_off), right_sp);
                    end
                    if (dir != 0) begin
                        od = dir > 0 ? longint'(cfg.ostep) : -longint'(cfg.ostep);
                        pd = dir > 0 ? -longint'(cfg.pstep) : longint'(cfg.pstep);
                        hold_cnt = '0;
                        o_corrections++;
                    end
                end
            end
            default: ;
        endcase
        orient_acc       = sat_sum(orient_acc, od);
        pos_acc          = sat_sum(pos_acc, pd);
        r.orient_delta   = od[15:0];
        r.pos_delta      = pd[15:0];
        r.orient_total   = orient_acc;
        r.pos_total      = pos_acc;
        r.enabled        = armed;
        r.left_rel       = left_fit >= cfg.fit_thr;
        r.right_rel      = right_fit >= cfg.fit_thr;
        return r;
    endfunction

    task automatic check_field(string name, longint expected, longint actual);
        if (expected != actual) begin
            if (o_mismatches < 10) begin
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, name, expected, actual);
            end
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg        = CFG_RESET;
            left_off   = '0;
            right_off  = '0;
            left_fit   = '0;
            right_fit  = '0;
            right_sp   = 16'(RSP_RESET);
            hold_cnt   = '0;
            armed      = 1'b0;
            orient_acc = '0;
            pos_acc    = '0;
            awaited_steer.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEFT_SP:  cfg.left_sp  = i_cfg_data;
                    CFG_DEADBAND: cfg.deadband = i_cfg_data;
                    CFG_FIT_THR:  cfg.fit_thr  = i_cfg_data[FIT_W-1:0];
                    CFG_MARGIN:   cfg.margin   = i_cfg_data;
                    CFG_OSTEP:    cfg.ostep    = i_cfg_data;
                    CFG_PSTEP:    cfg.pstep    = i_cfg_data;
                    CFG_HOLDOFF:  cfg.holdoff  = i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                awaited_steer.push_back(steer_for_request(i_req_mode, i_req_data));
            end
            if (i_res_valid && i_res_ready) begin
                if (awaited_steer.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("%0t: result arrived with no request outstanding", $time);
                    end
                    o_mismatches++;
                end else begin
                    want = awaited_steer.pop_front();
                    got  = i_res_data[RES_W-1:0];
                    check_field("orientation_delta", want.orient_delta, got.orient_delta);
                    check_field("position_delta", want.pos_delta, got.pos_delta);
                    check_field("orientation_total", want.orient_total, got.orient_total);
                    check_field("position_total", want.pos_total, got.pos_total);
                    check_field("enabled", want.enabled, got.enabled);
                    check_field("left_reliable", want.left_rel, got.left_rel);
                    check_field("right_reliable", want.right_rel, got.right_rel);
                    check_field("zero fill", 0, longint'(i_res_data[OUT_TW-1:RES_W]));
                    o_checked++;
                end
            end
        end
        o_pending = awaited_steer.size();
    end

endmodule

@@ dv/curb_following_offset_controller_tb.sv @@
// Stimulus and verdict for the curb-following offset controller. The checker
// beside the block predicts every result and counts mismatches; this module
// only produces requests, register writes and output back-pressure.
module curb_following_offset_controller_tb;
    import cfoc_pkg::*;

    // Channel widths: request tdata is distance (16) and fit (9) padded to
    // whole bytes, result tdata is 16+16+32+32+3 bits padded the same way.
    localparam int IN_TW          = 32;
    localparam int OUT_TW         = 104;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 6;

    // The two mode codes the block does not define; they must change nothing.
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // Fields from bit 0: curb_distance (16, signed), fit_quality (9), zero fill.
    logic [IN_TW-1:0]      s_axis_tdata  = '0;
    // Fields from bit 0: mode (3).
    logic [MODE_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // Fields from bit 0: orientation_delta (16), position_delta (16),
    // orientation_total (32), position_total (32), enabled, left_reliable,
    // right_reliable, zero fill.
    logic [OUT_TW-1:0]     m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int mismatches;
    int pending;
    int checked;
    int corrections;
    int clamps;
    int quiet_cycles = 0;

    // When set, neither side inserts idle or stall cycles.
    bit steady = 1'b0;

    // Current left setpoint and deadband, used to aim curb distances at the
    // interesting region around the band edges.
    int lsp_now = 512;
    int db_now  = 64;

    curb_following_offset_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    curb_following_offset_checker #(
        .IN_TW  (IN_TW),
        .OUT_TW (OUT_TW)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_mode    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_corrections (corrections),
        .o_clamps      (clamps)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls with a probability of about 30 percent unless steady.
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 30);
    end

    // A run that stops moving requests and results is a hang, not a slow run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, pending);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one request from a falling edge and returns at the falling edge
    // after the rising edge that accepted it, so that the next request can be
    // placed without lowering tvalid in between.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic signed [15:0] curb_dist,
                                input logic [FIT_W-1:0] fit);
        while (!steady && $urandom_range(99) < 30) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(IN_TW - 16 - FIT_W){1'b0}}, fit, curb_dist};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge i_clk);
    endtask

    // Writes every register in index order; only called while the block is idle.
    task automatic program_regs(input int left_sp, input int deadband, input int fit_thr,
                                input int margin, input int ostep, input int pstep,
                                input int holdoff);
        write_reg(CFG_LEFT_SP, left_sp);
        write_reg(CFG_DEADBAND, deadband);
        write_reg(CFG_FIT_THR, fit_thr);
        write_reg(CFG_MARGIN, margin);
        write_reg(CFG_OSTEP, ostep);
        write_reg(CFG_PSTEP, pstep);
        write_reg(CFG_HOLDOFF, holdoff);
        i_cfg_we <= 1'b0;
        lsp_now = left_sp;
        db_now  = deadband;
    endtask

    // Waits until every predicted result has been seen, then lets the two
    // pipeline stages settle before anything touches the registers.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Mostly distances near the setpoint band, some fully random, a few extremes.
    function automatic logic signed [15:0] pick_distance(input int center);
        int spread;
        int offset;
        int value;
        int r;
        r      = $urandom_range(99);
        spread = 2 * db_now + 64;
        if (spread > 20000) spread = 20000;
        if (r < 70) begin
            offset = int'($urandom_range(2 * spread)) - spread;
            value  = center + offset;
            if (value > 32767) value = 32767;
            if (value < -32768) value = -32768;
            return value[15:0];
        end else if (r < 90) begin
            return 16'($urandom_range(65535));
        end
        case ($urandom_range(3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // A perfect fit is common, a zero fit and raw values past 256 occasional.
    function automatic logic [FIT_W-1:0] pick_fit();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 9'd256;
        if (r < 45) return 9'd0;
        if (r < 50) return 9'($urandom_range(511, 257));
        return 9'($urandom_range(255));
    endfunction

    // Well-formed traffic: curb updates aimed at the band and a share of ticks
    // set by the caller, with rare nudges, toggles and undefined modes.
    task automatic send_random(input int count, input int tick_pct);
        int r;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < tick_pct) begin
                send_request(MODE_TICK, 16'($urandom_range(65535)), 9'($urandom_range(511)));
            end else begin
                r = $urandom_range(99);
                if (r < 38) begin
                    send_request(MODE_LEFT, pick_distance(lsp_now), pick_fit());
                end else if (r < 76) begin
                    // Right distance is the negated offset, so aim the offset
                    // at minus the expected right setpoint.
                    send_request(MODE_RIGHT, pick_distance(-lsp_now), pick_fit());
                end else if (r < 85) begin
                    send_request(MODE_NUDGE_UP, 16'($urandom_range(65535)),
                                 9'($urandom_range(511)));
                end else if (r < 94) begin
                    send_request(MODE_NUDGE_DN, 16'($urandom_range(65535)),
                                 9'($urandom_range(511)));
                end else if (r < 97) begin
                    send_request(MODE_TOGGLE, 16'($urandom_range(65535)),
                                 9'($urandom_range(511)));
                end else begin
                    send_request($urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B,
                                 16'($urandom_range(65535)), 9'($urandom_range(511)));
                end
            end
        end
    endtask

    initial begin
        // Synchronous reset held from time zero, released on a falling edge.
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, register defaults. A tick while disabled does nothing,
        // then the nudges, the undefined modes and the enable toggle.
        send_request(MODE_TICK, 16'sd0, 9'd0);
        send_request(MODE_NUDGE_UP, 16'sd0, 9'd0);
        send_request(MODE_NUDGE_DN, 16'sd0, 9'd0);
        send_request(MODE_SPARE_A, 16'sd0, 9'd0);
        send_request(MODE_SPARE_B, 16'sd0, 9'd0);
        send_request(MODE_TOGGLE, 16'sd0, 9'd0);
        // Left curb alone, close in: the third tick passes the holdoff and
        // steers right.
        send_request(MODE_LEFT, 16'sd0, 9'd256);
        repeat (3) send_request(MODE_TICK, 16'sd0, 9'd0);
        // Both curbs reliable, the right one with a raw fit past 256 and the
        // left exactly at threshold; the retargeted setpoint clamps high.
        send_request(MODE_RIGHT, 16'sh8000, 9'd511);
        send_request(MODE_LEFT, 16'sh7fff, 9'd128);
        repeat (4) send_request(MODE_TICK, 16'sd0, 9'd0);
        // Left fit one below threshold, so only the right curb is regulated.
        send_request(MODE_LEFT, 16'sh8000, 9'd127);
        send_request(MODE_RIGHT, 16'sh7fff, 9'd200);
        repeat (4) send_request(MODE_TICK, 16'sd0, 9'd0);
        // Setpoint retarget that clamps low.
        send_request(MODE_LEFT, 16'sh8000, 9'd256);
        send_request(MODE_RIGHT, 16'sh7fff, 9'd256);
        repeat (4) send_request(MODE_TICK, 16'sd0, 9'd0);
        wait_drained();

        send_random(400, 40);
        wait_drained();

        // Low extremes: no deadband, every curb reliable, maximum steps and no
        // holdoff, so every due tick corrects unless its distance equals the setpoint.
        program_regs(0, 0, 0, 0, 32767, 32767, 0);
        send_random(300, 40);
        wait_drained();

        // High extremes: only perfect or out-of-range fits count and the
        // holdoff counter has to reach saturation before a decision.
        program_regs(32767, 32767, 256, 32767, 0, 0, 254);
        send_random(300, 90);
        wait_drained();

        // Two random mid-range settings, with a stretch free of idling.
        repeat (2) begin
            program_regs($urandom_range(2000, 200), $urandom_range(300),
                         $urandom_range(256), $urandom_range(2048),
                         $urandom_range(32767), $urandom_range(32767),
                         $urandom_range(6));
            send_random(100, 45);
            steady = 1'b1;
            send_random(100, 45);
            steady = 1'b0;
            send_random(100, 45);
            wait_drained();
        end

        $display("Checked %0d results over five register settings: %0d automatic corrections,",
                 checked, corrections);
        $display("%0d clamped right setpoints, %0d mismatches.", clamps, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/cfoc_pkg.sv
hdl/cfoc_front.sv
hdl/cfoc_queue.sv
hdl/cfoc_back.sv
hdl/curb_following_offset_controller.sv
dv/curb_following_offset_checker.sv
dv/curb_following_offset_controller_tb.sv
